>>> src/cjt_pkg.sv
// shared widths, register codes and lane result type for the cubic joint trajectory block
// no dependencies; used by cjt_divider, cjt_lane and cubic_joint_trajectory
package cjt_pkg;

    // field widths
    localparam int ANG_W   = 16;
    localparam int TICK_W  = 16;
    localparam int SPEED_W = 20;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int LEG_W   = 2;

    // internal arithmetic widths
    localparam int QUO_W   = 16;   // rounded offset never exceeds |goal - start|
    localparam int DEN_W   = 48;   // duration cubed
    localparam int NUM_W   = 48;   // t^2 * (3T - 2t), bounded by T^3
    localparam int SQ_W    = 32;
    localparam int K_W     = 18;
    localparam int HALF_W  = 24;   // split point of the magnitude product
    localparam int PP_W    = 40;   // 16 x 24 partial product
    localparam int DIVD_W  = 64;
    localparam int DIFF_W  = 17;
    localparam int VRAW_W  = 34;

    // pipeline shape
    localparam int LANES      = 3;
    localparam int LANE_PRE   = 4;
    localparam int LANE_POST  = 2;
    localparam int PIPE_DEPTH = 1 + LANE_PRE + QUO_W + LANE_POST;

    // register reset values
    localparam logic [CFG_W-1:0] DUR_RESET  = 16'd1000;
    localparam logic [CFG_W-1:0] RATE_RESET = 16'd1000;

    // speed saturation limits
    localparam logic signed [VRAW_W-1:0] SPEED_MAX = 34'sd524287;
    localparam logic signed [VRAW_W-1:0] SPEED_MIN = -34'sd524288;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0]
    {
        REG_DURATION = 2'd0,
        REG_RATE     = 2'd1
    } cfg_index_t;

    // what one joint lane hands to the merge stage
    typedef struct packed
    {
        logic signed [ANG_W-1:0]  target;
        logic signed [VRAW_W-1:0] speed_raw;
    } lane_res_t;

endpackage

>>> src/cjt_divider.sv
// pipelined restoring divider, one quotient bit per stage
// depends on cjt_pkg for widths; quotient is known to fit in QUO_W bits
module cjt_divider
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [cjt_pkg::DIVD_W-1:0]   dividend,
    input  logic [cjt_pkg::DEN_W-1:0]    den,
    output logic [cjt_pkg::QUO_W-1:0]    quotient
);

    localparam int QW = cjt_pkg::QUO_W;
    localparam int DW = cjt_pkg::DIVD_W;

    logic [DW-1:0] rem_reg [0:QW-2];
    logic [QW-1:0] q_reg   [0:QW-1];

    genvar s;
    for (s = 0; s < QW; s++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] dsh;
        logic [QW-1:0] q_in;
        logic [QW-1:0] q_next;
        logic          take;

        // stage input
        if (s == 0)
        begin : g_first
            assign rem_in = dividend;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        // trial subtract of the shifted divisor
        assign dsh    = {{(DW - cjt_pkg::DEN_W){1'b0}}, den} << (QW - 1 - s);
        assign take   = rem_in >= dsh;
        assign q_next = q_in | (take ? (QW'(1) << (QW - 1 - s)) : '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s] <= q_next;
            end
        end

        // partial remainder, not needed after the last bit
        if (s < QW - 1)
        begin : g_rem
            logic [DW-1:0] rem_next;
            assign rem_next = take ? (rem_in - dsh) : rem_in;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                end
            end
        end
    end

    assign quotient = q_reg[QW-1];

endmodule

>>> src/cjt_lane.sv
// one joint lane: cubic blend weight, rounded offset at two ticks, raw velocity
// depends on cjt_pkg and cjt_divider
module cjt_lane
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [cjt_pkg::TICK_W-1:0]          t0,
    input  logic [cjt_pkg::TICK_W-1:0]          t1,
    input  logic [cjt_pkg::TICK_W-1:0]          dur,
    input  logic [cjt_pkg::DEN_W-1:0]           den,
    input  logic [cjt_pkg::CFG_W-1:0]           rate,
    input  logic signed [cjt_pkg::ANG_W-1:0]    start,
    input  logic signed [cjt_pkg::ANG_W-1:0]    goal,
    output cjt_pkg::lane_res_t                  res
);

    localparam int AW = cjt_pkg::ANG_W;
    localparam int QW = cjt_pkg::QUO_W;

    typedef struct packed
    {
        logic signed [AW-1:0] start;
        logic                 neg;
    } side_t;

    // stage 1: magnitude of the travel, t squared, 3T - 2t
    logic [AW:0]                   d_next;
    logic [AW:0]                   mag_full;
    logic [QW-1:0]                 mag1_reg;
    logic                          neg1_reg;
    logic signed [AW-1:0]          start1_reg;
    logic [cjt_pkg::SQ_W-1:0]      t0sq_reg, t1sq_reg;
    logic [cjt_pkg::K_W-1:0]       k0_reg, k1_reg;
    logic [cjt_pkg::K_W-1:0]       three_t;

    assign d_next   = {goal[AW-1], goal} - {start[AW-1], start};
    assign mag_full = d_next[AW] ? ((AW+1)'(0) - d_next) : d_next;
    assign three_t  = {2'b00, dur} + {1'b0, dur, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg   <= mag_full[QW-1:0];
            neg1_reg   <= d_next[AW];
            start1_reg <= start;
            t0sq_reg   <= {16'b0, t0} * {16'b0, t0};
            t1sq_reg   <= {16'b0, t1} * {16'b0, t1};
            k0_reg     <= three_t - {1'b0, t0, 1'b0};
            k1_reg     <= three_t - {1'b0, t1, 1'b0};
        end
    end

    // stage 2: numerator t^2 * (3T - 2t)
    logic [QW-1:0]                 mag2_reg;
    logic                          neg2_reg;
    logic signed [AW-1:0]          start2_reg;
    logic [cjt_pkg::NUM_W-1:0]     num0_reg, num1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag2_reg   <= mag1_reg;
            neg2_reg   <= neg1_reg;
            start2_reg <= start1_reg;
            num0_reg   <= {16'b0, t0sq_reg} * {30'b0, k0_reg};
            num1_reg   <= {16'b0, t1sq_reg} * {30'b0, k1_reg};
        end
    end

    // stage 3: magnitude times numerator, split in two halves
    logic                          neg3_reg;
    logic signed [AW-1:0]          start3_reg;
    logic [cjt_pkg::PP_W-1:0]      pl0_reg, ph0_reg, pl1_reg, ph1_reg;
    logic [cjt_pkg::PP_W-1:0]      mag_ext;

    assign mag_ext = {{(cjt_pkg::PP_W - QW){1'b0}}, mag2_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg3_reg   <= neg2_reg;
            start3_reg <= start2_reg;
            pl0_reg    <= mag_ext * {16'b0, num0_reg[cjt_pkg::HALF_W-1:0]};
            ph0_reg    <= mag_ext * {16'b0, num0_reg[cjt_pkg::NUM_W-1:cjt_pkg::HALF_W]};
            pl1_reg    <= mag_ext * {16'b0, num1_reg[cjt_pkg::HALF_W-1:0]};
            ph1_reg    <= mag_ext * {16'b0, num1_reg[cjt_pkg::NUM_W-1:cjt_pkg::HALF_W]};
        end
    end

    // stage 4: full product plus half the divisor for round to nearest
    logic                          neg4_reg;
    logic signed [AW-1:0]          start4_reg;
    logic [cjt_pkg::DIVD_W-1:0]    dvd0_reg, dvd1_reg;
    logic [cjt_pkg::DIVD_W-1:0]    half_ext;

    assign half_ext = {{(cjt_pkg::DIVD_W - cjt_pkg::DEN_W + 1){1'b0}},
                       den[cjt_pkg::DEN_W-1:1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg4_reg   <= neg3_reg;
            start4_reg <= start3_reg;
            dvd0_reg   <= {ph0_reg, 24'b0} + {24'b0, pl0_reg} + half_ext;
            dvd1_reg   <= {ph1_reg, 24'b0} + {24'b0, pl1_reg} + half_ext;
        end
    end

    // division by T^3, one quotient bit per stage
    logic [QW-1:0] q0, q1;

    cjt_divider u_div0
    (
        .clk      (clk),
        .en       (en),
        .dividend (dvd0_reg),
        .den      (den),
        .quotient (q0)
    );

    cjt_divider u_div1
    (
        .clk      (clk),
        .en       (en),
        .dividend (dvd1_reg),
        .den      (den),
        .quotient (q1)
    );

    // sign and start carried alongside the divider stages
    side_t side_reg [0:QW-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{start: start4_reg, neg: neg4_reg};
            for (int i = 1; i < QW; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // stage 5: the two positions and their difference
    localparam int DIFF_W_L = cjt_pkg::DIFF_W;
    side_t                        side_out;
    logic [AW:0]                  p0_sum, p1_sum;
    logic signed [AW-1:0]         p0_reg;
    logic signed [DIFF_W_L-1:0]   diff_reg;

    assign side_out = side_reg[QW-1];
    assign p0_sum   = side_out.neg ? ({side_out.start[AW-1], side_out.start} - {1'b0, q0})
                                   : ({side_out.start[AW-1], side_out.start} + {1'b0, q0});
    assign p1_sum   = side_out.neg ? ({side_out.start[AW-1], side_out.start} - {1'b0, q1})
                                   : ({side_out.start[AW-1], side_out.start} + {1'b0, q1});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg   <= p0_sum[AW-1:0];
            diff_reg <= {p1_sum[AW-1], p1_sum[AW-1:0]} - {p0_sum[AW-1], p0_sum[AW-1:0]};
        end
    end

    // stage 6: per-tick change scaled by the tick rate
    logic signed [AW-1:0]              target_reg;
    logic signed [cjt_pkg::VRAW_W-1:0] vel_reg;
    logic signed [cjt_pkg::VRAW_W-1:0] diff_ext;
    logic signed [cjt_pkg::VRAW_W-1:0] rate_ext;

    assign diff_ext = $signed({{(cjt_pkg::VRAW_W - DIFF_W_L){diff_reg[DIFF_W_L-1]}}, diff_reg});
    assign rate_ext = $signed({{(cjt_pkg::VRAW_W - cjt_pkg::CFG_W){1'b0}}, rate});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            target_reg <= p0_reg;
            vel_reg    <= diff_ext * rate_ext;
        end
    end

    assign res.target    = target_reg;
    assign res.speed_raw = vel_reg;

endmodule

>>> src/cubic_joint_trajectory.sv
// cubic joint trajectory: items pass input, lane and merge registers to result valid
// one item per cycle unless stalled; the 16-stage offset dividers in each lane set the depth
// a held result stalls the whole pipeline until it is taken
// reset: duration and rate registers return to 1000, all valid flags clear
// no clearing pass; items are accepted from the first cycle after reset
// depends on cjt_pkg, cjt_lane, cjt_divider
module cubic_joint_trajectory
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_write,
    input  logic [cjt_pkg::IDX_W-1:0]             cfg_index,
    input  logic [cjt_pkg::CFG_W-1:0]             cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [cjt_pkg::LEG_W-1:0]             leg_index,
    input  logic [cjt_pkg::TICK_W-1:0]            elapsed_ticks,
    input  logic signed [cjt_pkg::ANG_W-1:0]      start_hip_x,
    input  logic signed [cjt_pkg::ANG_W-1:0]      start_hip_y,
    input  logic signed [cjt_pkg::ANG_W-1:0]      start_knee,
    input  logic signed [cjt_pkg::ANG_W-1:0]      goal_hip_x,
    input  logic signed [cjt_pkg::ANG_W-1:0]      goal_hip_y,
    input  logic signed [cjt_pkg::ANG_W-1:0]      goal_knee,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [cjt_pkg::LEG_W-1:0]             out_leg_index,
    output logic signed [cjt_pkg::ANG_W-1:0]      target_hip_x,
    output logic signed [cjt_pkg::ANG_W-1:0]      target_hip_y,
    output logic signed [cjt_pkg::ANG_W-1:0]      target_knee,
    output logic signed [cjt_pkg::SPEED_W-1:0]    speed_hip_x,
    output logic signed [cjt_pkg::SPEED_W-1:0]    speed_hip_y,
    output logic signed [cjt_pkg::SPEED_W-1:0]    speed_knee
);

    localparam int DEPTH = cjt_pkg::PIPE_DEPTH;
    localparam int NL    = cjt_pkg::LANES;
    localparam int TW    = cjt_pkg::TICK_W;
    localparam int AW    = cjt_pkg::ANG_W;
    localparam int SW    = cjt_pkg::SPEED_W;

    // configuration registers
    logic [cjt_pkg::CFG_W-1:0] dur_reg, rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg  <= cjt_pkg::DUR_RESET;
            rate_reg <= cjt_pkg::RATE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cjt_pkg::REG_DURATION: dur_reg  <= cfg_data;
                cjt_pkg::REG_RATE:     rate_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // effective duration and its cube; after a write the cube settles through sq_reg, then den_reg
    logic [TW-1:0]                dur_eff;
    logic [cjt_pkg::SQ_W-1:0]     sq_reg;
    logic [cjt_pkg::DEN_W-1:0]    den_reg;

    assign dur_eff = (dur_reg == '0) ? TW'(1) : dur_reg;

    always_ff @(posedge clk)
    begin
        sq_reg  <= {16'b0, dur_eff} * {16'b0, dur_eff};
        den_reg <= {16'b0, sq_reg} * {32'b0, dur_eff};
    end

    // pipeline advance: freeze only while a result waits and is stalled
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // input stage: clamp time to the motion length
    logic [TW-1:0]        t0_next, t1_next;
    logic [TW:0]          t0_inc;
    logic [TW-1:0]        t0_reg, t1_reg;
    logic signed [AW-1:0] start_reg [0:NL-1];
    logic signed [AW-1:0] goal_reg  [0:NL-1];

    assign t0_next = (elapsed_ticks < dur_eff) ? elapsed_ticks : dur_eff;
    assign t0_inc  = {1'b0, t0_next} + (TW+1)'(1);
    assign t1_next = (t0_inc < {1'b0, dur_eff}) ? t0_inc[TW-1:0] : dur_eff;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg       <= t0_next;
            t1_reg       <= t1_next;
            start_reg[0] <= start_hip_x;
            start_reg[1] <= start_hip_y;
            start_reg[2] <= start_knee;
            goal_reg[0]  <= goal_hip_x;
            goal_reg[1]  <= goal_hip_y;
            goal_reg[2]  <= goal_knee;
        end
    end

    // valid flags and leg index follow the item down the pipeline
    logic [DEPTH-1:0]             vld_reg;
    logic [cjt_pkg::LEG_W-1:0]    leg_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[DEPTH-2:0], in_valid};
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            leg_reg[0] <= leg_index;
            for (int i = 1; i < DEPTH; i++)
            begin
                leg_reg[i] <= leg_reg[i-1];
            end
        end
    end

    // joint lanes
    cjt_pkg::lane_res_t lane_res [0:NL-1];

    genvar j;
    for (j = 0; j < NL; j++)
    begin : g_lane
        cjt_lane u_lane
        (
            .clk   (clk),
            .en    (adv),
            .t0    (t0_reg),
            .t1    (t1_reg),
            .dur   (dur_eff),
            .den   (den_reg),
            .rate  (rate_reg),
            .start (start_reg[j]),
            .goal  (goal_reg[j]),
            .res   (lane_res[j])
        );
    end

    // speed saturation to the output range
    function automatic logic signed [SW-1:0] sat_speed(input logic signed [cjt_pkg::VRAW_W-1:0] v);
        logic signed [SW-1:0] r;
        if (v > cjt_pkg::SPEED_MAX)
        begin
            r = cjt_pkg::SPEED_MAX[SW-1:0];
        end
        else if (v < cjt_pkg::SPEED_MIN)
        begin
            r = cjt_pkg::SPEED_MIN[SW-1:0];
        end
        else
        begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // merge stage: gather lane results into the output register
    logic [cjt_pkg::LEG_W-1:0]    out_leg_reg;
    logic signed [AW-1:0]         target_reg [0:NL-1];
    logic signed [SW-1:0]         speed_reg  [0:NL-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_leg_reg <= leg_reg[DEPTH-1];
            for (int i = 0; i < NL; i++)
            begin
                target_reg[i] <= lane_res[i].target;
                speed_reg[i]  <= sat_speed(lane_res[i].speed_raw);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_leg_index = out_leg_reg;
    assign target_hip_x  = target_reg[0];
    assign target_hip_y  = target_reg[1];
    assign target_knee   = target_reg[2];
    assign speed_hip_x   = speed_reg[0];
    assign speed_hip_y   = speed_reg[1];
    assign speed_knee    = speed_reg[2];

    // an item leaving the last lane stage becomes a valid result
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[DEPTH-1] |=> out_valid_reg)
        else $error("item lost between lane output and result register");

    // input is only held back by a result that waits
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("input stalled without a waiting result");

    // divisor settles to a non-zero cube shortly after reset or a write
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 2) && !$past(cfg_write) && !$past(cfg_write, 2) |-> den_reg != '0)
        else $error("duration cube is zero");

endmodule

>>> sim/cubic_joint_trajectory_tb.sv
// self-checking testbench for cubic_joint_trajectory: directed corner items, then random phases
// predicts each setpoint from its own copy of the registers; depends on cjt_pkg and the block
`timescale 1ns / 1ps

module cubic_joint_trajectory_tb;

    // timing and stimulus sizes
    localparam int CLK_HALF       = 1;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 32;
    localparam int MAX_GAP        = 11;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 106;
    localparam int PRESSURE_PHASE = 5;
    localparam int PRESSURE_START = 20;

    // angle extremes in Q2.13
    localparam logic [cjt_pkg::ANG_W-1:0] ANG_MIN = 16'h8000;
    localparam logic [cjt_pkg::ANG_W-1:0] ANG_MAX = 16'h7FFF;

    // register indexes with no register behind them
    localparam logic [cjt_pkg::IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [cjt_pkg::IDX_W-1:0] REG_SPARE_B = 2'd3;

    // one leg command, joints ordered hip_x, hip_y, knee
    typedef struct packed
    {
        logic [cjt_pkg::LEG_W-1:0]                       leg;
        logic [cjt_pkg::TICK_W-1:0]                      ticks;
        logic [cjt_pkg::LANES-1:0][cjt_pkg::ANG_W-1:0]   start_ang;
        logic [cjt_pkg::LANES-1:0][cjt_pkg::ANG_W-1:0]   goal_ang;
    } leg_command_t;

    // one leg setpoint as the block returns it
    typedef struct packed
    {
        logic [cjt_pkg::LEG_W-1:0]                       leg;
        logic [cjt_pkg::LANES-1:0][cjt_pkg::ANG_W-1:0]   target;
        logic [cjt_pkg::LANES-1:0][cjt_pkg::SPEED_W-1:0] speed;
    } leg_setpoint_t;

    // setpoint predictor and in-order checker
    class trajectory_scoreboard;
        logic [cjt_pkg::CFG_W-1:0] duration;
        logic [cjt_pkg::CFG_W-1:0] rate;
        leg_setpoint_t             pending [$];
        int                        failures;
        string                     joint_label [3];

        function new();
            duration    = cjt_pkg::DUR_RESET;
            rate        = cjt_pkg::RATE_RESET;
            failures    = 0;
            joint_label = '{"hip_x", "hip_y", "knee"};
        endfunction

        function void write_reg(logic [cjt_pkg::IDX_W-1:0] idx,
                                logic [cjt_pkg::CFG_W-1:0] value);
            if (idx == cjt_pkg::REG_DURATION)
                duration = value;
            else if (idx == cjt_pkg::REG_RATE)
                rate = value;
        endfunction

        // cubic blend at tick t of span, offset rounded half away from zero
        function logic signed [cjt_pkg::ANG_W-1:0] joint_angle(
                logic signed [cjt_pkg::ANG_W-1:0] from_ang,
                logic signed [cjt_pkg::ANG_W-1:0] to_ang,
                int unsigned t, int unsigned span);
            logic signed [17:0] delta;
            logic signed [17:0] offset;
            logic signed [17:0] pos;
            logic [79:0]        mag;
            logic [79:0]        tw;
            logic [79:0]        sw;
            logic [79:0]        num;
            logic [79:0]        den;
            logic [79:0]        quo;
            delta  = to_ang - from_ang;
            mag    = (delta < 0) ? 80'(-delta) : 80'(delta);
            tw     = 80'(t);
            sw     = 80'(span);
            num    = tw * tw * (3 * sw - 2 * tw);
            den    = sw * sw * sw;
            quo    = (mag * num + den / 2) / den;
            offset = signed'({1'b0, quo[16:0]});
            pos    = (delta < 0) ? from_ang - offset : from_ang + offset;
            return pos[cjt_pkg::ANG_W-1:0];
        endfunction

        function void note_command(leg_command_t cmd);
            leg_setpoint_t                    want;
            int unsigned                      span;
            int unsigned                      t_now;
            int unsigned                      t_next;
            logic signed [cjt_pkg::ANG_W-1:0] p_now;
            logic signed [cjt_pkg::ANG_W-1:0] p_next;
            longint                           vel;
            span     = (duration == 0) ? 1 : duration;
            t_now    = (cmd.ticks < span) ? cmd.ticks : span;
            t_next   = (t_now + 1 < span) ? t_now + 1 : span;
            want.leg = cmd.leg;
            for (int j = 0; j < cjt_pkg::LANES; j++)
            begin
                p_now  = joint_angle(cmd.start_ang[j], cmd.goal_ang[j], t_now, span);
                p_next = joint_angle(cmd.start_ang[j], cmd.goal_ang[j], t_next, span);
                vel    = (longint'(p_next) - longint'(p_now)) * longint'(rate);
                if (vel > cjt_pkg::SPEED_MAX)
                    vel = cjt_pkg::SPEED_MAX;
                if (vel < cjt_pkg::SPEED_MIN)
                    vel = cjt_pkg::SPEED_MIN;
                want.target[j] = p_now;
                want.speed[j]  = vel[cjt_pkg::SPEED_W-1:0];
            end
            pending.push_back(want);
        endfunction

        function void check_setpoint(leg_setpoint_t got);
            leg_setpoint_t want;
            if (pending.size() == 0)
            begin
                failures++;
                $error("setpoint transfer with no command outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.leg !== want.leg)
            begin
                failures++;
                $error("out_leg_index: expected %0d, got %0d", want.leg, got.leg);
            end
            for (int j = 0; j < cjt_pkg::LANES; j++)
            begin
                if (got.target[j] !== want.target[j])
                begin
                    failures++;
                    $error("target_%s: expected %0d, got %0d", joint_label[j],
                           $signed(want.target[j]), $signed(got.target[j]));
                end
                if (got.speed[j] !== want.speed[j])
                begin
                    failures++;
                    $error("speed_%s: expected %0d, got %0d", joint_label[j],
                           $signed(want.speed[j]), $signed(got.speed[j]));
                end
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_write;
    logic [cjt_pkg::IDX_W-1:0]          cfg_index;
    logic [cjt_pkg::CFG_W-1:0]          cfg_data;
    logic                               in_valid;
    logic                               in_stall;
    logic [cjt_pkg::LEG_W-1:0]          leg_index;
    logic [cjt_pkg::TICK_W-1:0]         elapsed_ticks;
    logic signed [cjt_pkg::ANG_W-1:0]   start_hip_x;
    logic signed [cjt_pkg::ANG_W-1:0]   start_hip_y;
    logic signed [cjt_pkg::ANG_W-1:0]   start_knee;
    logic signed [cjt_pkg::ANG_W-1:0]   goal_hip_x;
    logic signed [cjt_pkg::ANG_W-1:0]   goal_hip_y;
    logic signed [cjt_pkg::ANG_W-1:0]   goal_knee;
    logic                               out_valid;
    logic                               out_stall;
    logic [cjt_pkg::LEG_W-1:0]          out_leg_index;
    logic signed [cjt_pkg::ANG_W-1:0]   target_hip_x;
    logic signed [cjt_pkg::ANG_W-1:0]   target_hip_y;
    logic signed [cjt_pkg::ANG_W-1:0]   target_knee;
    logic signed [cjt_pkg::SPEED_W-1:0] speed_hip_x;
    logic signed [cjt_pkg::SPEED_W-1:0] speed_hip_y;
    logic signed [cjt_pkg::SPEED_W-1:0] speed_knee;

    // idling modes for the sender and the receiver, and the receiver's long-hold request
    bit tx_idle;
    bit rx_idle;
    bit hold_request;

    trajectory_scoreboard board = new();

    cubic_joint_trajectory dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .leg_index     (leg_index),
        .elapsed_ticks (elapsed_ticks),
        .start_hip_x   (start_hip_x),
        .start_hip_y   (start_hip_y),
        .start_knee    (start_knee),
        .goal_hip_x    (goal_hip_x),
        .goal_hip_y    (goal_hip_y),
        .goal_knee     (goal_knee),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_leg_index (out_leg_index),
        .target_hip_x  (target_hip_x),
        .target_hip_y  (target_hip_y),
        .target_knee   (target_knee),
        .speed_hip_x   (speed_hip_x),
        .speed_hip_y   (speed_hip_y),
        .speed_knee    (speed_knee)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // transfer monitor: results are checked before the new command is noted
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid && !out_stall)
                board.check_setpoint('{out_leg_index,
                                       {target_knee, target_hip_y, target_hip_x},
                                       {speed_knee, speed_hip_y, speed_hip_x}});
            if (in_valid && !in_stall)
                board.note_command('{leg_index, elapsed_ticks,
                                     {start_knee, start_hip_y, start_hip_x},
                                     {goal_knee, goal_hip_y, goal_hip_x}});
        end
    end

    // receiver: random stall per setpoint while rx_idle is set, one long hold when asked
    initial
    begin : receiver
        int stall_len;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_len    = LONG_HOLD;
            end
            else
                stall_len = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // offer one command after an optional random gap and hold it until transferred
    task automatic send_command(input leg_command_t cmd);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        leg_index     <= cmd.leg;
        elapsed_ticks <= cmd.ticks;
        start_hip_x   <= cmd.start_ang[0];
        start_hip_y   <= cmd.start_ang[1];
        start_knee    <= cmd.start_ang[2];
        goal_hip_x    <= cmd.goal_ang[0];
        goal_hip_y    <= cmd.goal_ang[1];
        goal_knee     <= cmd.goal_ang[2];
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [cjt_pkg::IDX_W-1:0] idx,
                             input logic [cjt_pkg::CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        board.write_reg(idx, value);
        @(negedge clk);
    endtask

    // let every outstanding setpoint come back, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic leg_command_t make_cmd(logic [cjt_pkg::LEG_W-1:0] leg,
                                              logic [cjt_pkg::TICK_W-1:0] ticks,
                                              logic [cjt_pkg::ANG_W-1:0] sx,
                                              logic [cjt_pkg::ANG_W-1:0] sy,
                                              logic [cjt_pkg::ANG_W-1:0] sk,
                                              logic [cjt_pkg::ANG_W-1:0] gx,
                                              logic [cjt_pkg::ANG_W-1:0] gy,
                                              logic [cjt_pkg::ANG_W-1:0] gk);
        return '{leg, ticks, {sk, sy, sx}, {gk, gy, gx}};
    endfunction

    // extremes and zero turn up often, the rest is uniform
    function automatic logic [cjt_pkg::ANG_W-1:0] random_angle();
        case ($urandom_range(0, 7))
            0:       return ANG_MIN;
            1:       return ANG_MAX;
            2:       return '0;
            default: return cjt_pkg::ANG_W'($urandom);
        endcase
    endfunction

    // ticks mostly around the motion span, sometimes anywhere
    function automatic leg_command_t random_command(int unsigned span);
        leg_command_t cmd;
        int unsigned  top;
        top     = (span + 1 > 65535) ? 65535 : span + 1;
        cmd.leg = cjt_pkg::LEG_W'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0)
            cmd.ticks = cjt_pkg::TICK_W'($urandom_range(0, top));
        else
            cmd.ticks = cjt_pkg::TICK_W'($urandom);
        for (int j = 0; j < cjt_pkg::LANES; j++)
        begin
            cmd.start_ang[j] = random_angle();
            cmd.goal_ang[j]  = ($urandom_range(0, 7) == 0) ? cmd.start_ang[j] : random_angle();
        end
        return cmd;
    endfunction

    // stimulus
    initial
    begin : stimulus
        int unsigned span;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = cjt_pkg::REG_DURATION;
        cfg_data      = '0;
        in_valid      = 1'b0;
        leg_index     = '0;
        elapsed_ticks = '0;
        start_hip_x   = '0;
        start_hip_y   = '0;
        start_knee    = '0;
        goal_hip_x    = '0;
        goal_hip_y    = '0;
        goal_knee     = '0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        hold_request  = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: start, first tick, midpoint, last tick, end, far beyond, then a small step near the end
        send_command(make_cmd(0, 0, ANG_MIN, 0, 100, ANG_MAX, 0, -100));
        send_command(make_cmd(1, 1, ANG_MIN, 0, 100, ANG_MAX, 0, -100));
        send_command(make_cmd(2, 500, ANG_MAX, ANG_MIN, 1234, ANG_MIN, ANG_MAX, 1234));
        send_command(make_cmd(3, 999, ANG_MIN, ANG_MAX, -7, ANG_MAX, ANG_MIN, 9));
        send_command(make_cmd(0, 1000, ANG_MIN, ANG_MAX, -7, ANG_MAX, ANG_MIN, 9));
        send_command(make_cmd(1, 16'hFFFF, 3, -3, ANG_MIN, -3, 3, ANG_MAX));
        send_command(make_cmd(2, 998, 0, 0, 1, -1, 1, 0));
        drain();

        // one-tick motion with the highest rate: speeds saturate both ways
        write_reg(cjt_pkg::REG_DURATION, 16'd1);
        write_reg(cjt_pkg::REG_RATE, 16'hFFFF);
        send_command(make_cmd(3, 0, ANG_MIN, ANG_MAX, 0, ANG_MAX, ANG_MIN, 1));
        send_command(make_cmd(0, 0, ANG_MAX, ANG_MIN, 5, ANG_MIN, ANG_MAX, 4));
        send_command(make_cmd(1, 1, ANG_MIN, ANG_MAX, 0, ANG_MAX, ANG_MIN, 1));
        send_command(make_cmd(2, 16'hFFFF, ANG_MIN, 0, 0, ANG_MAX, 0, 0));
        drain();

        // zero duration behaves as one tick, zero rate gives no speed
        write_reg(cjt_pkg::REG_DURATION, 16'd0);
        write_reg(cjt_pkg::REG_RATE, 16'd0);
        send_command(make_cmd(0, 0, ANG_MIN, ANG_MAX, 0, ANG_MAX, ANG_MIN, 0));
        send_command(make_cmd(1, 2, ANG_MIN, ANG_MAX, 0, ANG_MAX, ANG_MIN, 0));
        drain();

        // longest motion at the highest rate
        write_reg(cjt_pkg::REG_DURATION, 16'hFFFF);
        write_reg(cjt_pkg::REG_RATE, 16'hFFFF);
        send_command(make_cmd(2, 16'd32767, ANG_MIN, ANG_MAX, 0, ANG_MAX, ANG_MIN, 0));
        send_command(make_cmd(3, 16'hFFFE, ANG_MIN, ANG_MAX, 0, ANG_MAX, ANG_MIN, 0));
        send_command(make_cmd(0, 0, ANG_MIN, ANG_MAX, 0, ANG_MAX, ANG_MIN, 0));
        drain();

        // two-tick motion: half-way offsets tie, spare indexes must change nothing
        write_reg(cjt_pkg::REG_DURATION, 16'd2);
        write_reg(cjt_pkg::REG_RATE, 16'd1);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'hFFFF);
        send_command(make_cmd(1, 1, 0, 0, 5, 1, -1, 2));
        send_command(make_cmd(2, 1, ANG_MAX, ANG_MIN, -5, 32766, -32767, -2));
        send_command(make_cmd(3, 0, 0, 0, 5, 1, -1, 2));
        drain();

        // random phases over a spread of register settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(cjt_pkg::REG_DURATION, cjt_pkg::CFG_W'($urandom_range(1, 16)));
                    write_reg(cjt_pkg::REG_RATE, cjt_pkg::CFG_W'($urandom));
                end
                1:
                begin
                    write_reg(cjt_pkg::REG_DURATION, 16'hFFFF);
                    write_reg(cjt_pkg::REG_RATE, 16'hFFFF);
                end
                2:
                begin
                    write_reg(cjt_pkg::REG_DURATION, 16'd1);
                    write_reg(cjt_pkg::REG_RATE, 16'd1);
                end
                3:
                begin
                    write_reg(cjt_pkg::REG_DURATION, 16'd0);
                    write_reg(cjt_pkg::REG_RATE, 16'd0);
                end
                5:
                begin
                    write_reg(cjt_pkg::REG_DURATION, cjt_pkg::CFG_W'($urandom_range(2, 64)));
                    write_reg(cjt_pkg::REG_RATE, cjt_pkg::CFG_W'($urandom_range(1, 65535)));
                end
                7:
                begin
                    write_reg(cjt_pkg::REG_DURATION, cjt_pkg::DUR_RESET);
                    write_reg(cjt_pkg::REG_RATE, cjt_pkg::RATE_RESET);
                end
                default:
                begin
                    write_reg(cjt_pkg::REG_DURATION, cjt_pkg::CFG_W'($urandom));
                    write_reg(cjt_pkg::REG_RATE, cjt_pkg::CFG_W'($urandom));
                end
            endcase
            write_reg(phase[0] ? REG_SPARE_B : REG_SPARE_A, cjt_pkg::CFG_W'($urandom));
            tx_idle = (phase % 2 == 0);
            rx_idle = (phase % 4 < 2);
            span    = (board.duration == 0) ? 1 : board.duration;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // receiver holds off while commands keep coming back to back
                if (phase == PRESSURE_PHASE && n == PRESSURE_START)
                    hold_request = 1'b1;
                send_command(random_command(span));
            end
            drain();
        end

        if (board.failures == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
